### hdl/keyed_record_table_macros.svh
// ----------------------------------------------------------------------------
// keyed_record_table_macros
// Assertion helpers shared by the keyed record table RTL.
// ----------------------------------------------------------------------------
`ifndef KEYED_RECORD_TABLE_MACROS_SVH
`define KEYED_RECORD_TABLE_MACROS_SVH

// same-cycle implication, disabled during reset
`define KRT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define KRT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/krt_pkg.sv
// ----------------------------------------------------------------------------
// krt_pkg
// Types, codes and constants of the keyed record table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package krt_pkg;

   localparam int DEFAULT_CAPACITY = 64;
   localparam int KEY_MAX          = 9999;
   localparam int KEY_W            = 14;
   localparam int HELD_W           = 7;

   typedef enum logic [2:0] {
      ACT_INSERT = 3'd0,
      ACT_LOOKUP = 3'd1,
      ACT_UPDATE = 3'd2,
      ACT_DELETE = 3'd3,
      ACT_LIST   = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      FLD_KEY   = 2'd0,
      FLD_PRICE = 2'd1,
      FLD_QTY   = 2'd2,
      FLD_ALL   = 2'd3
   } field_type;

   typedef enum logic [3:0] {
      STS_OK          = 4'd0,
      STS_FULL        = 4'd1,
      STS_BAD_KEY     = 4'd2,
      STS_DUPLICATE   = 4'd3,
      STS_NEG_PRICE   = 4'd4,
      STS_NEG_QTY     = 4'd5,
      STS_NOT_FOUND   = 4'd6,
      STS_EMPTY       = 4'd7,
      STS_BAD_NEW_KEY = 4'd8
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_INS_WR,
      ST_UPD_WR,
      ST_DEL_RD,
      ST_DEL_WR,
      ST_SORT_RD,
      ST_SORT_CMP,
      ST_SORT_WR,
      ST_LIST_RD,
      ST_LIST_EMIT
   } state_type;

   typedef struct packed {
      action_type         action;
      logic signed [15:0] key;
      logic signed [15:0] new_key;
      logic signed [31:0] price_cents;
      logic signed [31:0] quantity;
      field_type          which_field;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [KEY_W-1:0]    found_key;
      logic signed [31:0]  found_price;
      logic signed [31:0]  found_quantity;
      logic [HELD_W-1:0]   entries_held;
      logic                last;
   } rsp_type;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic signed [31:0] price;
      logic signed [31:0] quantity;
   } record_type;

   typedef struct packed {
      logic eq;
      logic gt;
   } cmp_type;

   function automatic logic key_in_range(input logic signed [15:0] k);
      return !k[15] && (k <= 16'sd9999);
   endfunction

endpackage

### hdl/krt_store.sv
// ----------------------------------------------------------------------------
// krt_store
// Record memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module krt_store #(
   parameter int CAPACITY = krt_pkg::DEFAULT_CAPACITY,
   localparam int IDX_W   = $clog2(CAPACITY)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [IDX_W-1:0]    wr_addr,
   input  krt_pkg::record_type wr_data,
   input  logic [IDX_W-1:0]    rd_addr_a,
   input  logic [IDX_W-1:0]    rd_addr_b,
   output krt_pkg::record_type rd_data_a,
   output krt_pkg::record_type rd_data_b
);

   krt_pkg::record_type mem [CAPACITY];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

### hdl/krt_keycmp.sv
// ----------------------------------------------------------------------------
// krt_keycmp
// Shared key comparator used by the search and the sort passes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module krt_keycmp (
   input  logic [krt_pkg::KEY_W-1:0] key_a,
   input  logic [krt_pkg::KEY_W-1:0] key_b,
   output krt_pkg::cmp_type          result
);

   always_comb begin
      result.eq = (key_a == key_b);
      result.gt = (key_a > key_b);
   end

endmodule

### hdl/keyed_record_table.sv
// ----------------------------------------------------------------------------
// keyed_record_table
// Bounded record table with insert, lookup, update, delete and sorted list.
// ----------------------------------------------------------------------------
//  channel   ports                          direction  transfer
//  request   start, busy, req_data          in         start && !busy
//  response  rsp_valid, rsp_data            out        rsp_valid, one cycle
//
//  Search reads and compares the entries in order until a match or the end.
//  Delete then shifts each later entry down one slot.
//  List runs a bubble sort over the entries and then emits them in ascending
//  key order; everything runs through one memory.
//  Reset clears the entry count and the sequencer; the memory is not cleared.
//  The receiver cannot stall: each response is shown for one cycle only.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "keyed_record_table_macros.svh"

module keyed_record_table #(
   parameter int CAPACITY = krt_pkg::DEFAULT_CAPACITY
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  krt_pkg::req_type req_data,
   output logic             rsp_valid,
   output krt_pkg::rsp_type rsp_data
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   krt_pkg::state_type  state_ff, state_in;
   krt_pkg::req_type    req_ff, req_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [IDX_W-1:0]    pass_ff, pass_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   krt_pkg::record_type rec_ff, rec_in;
   krt_pkg::rsp_type    rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   krt_pkg::record_type wr_data;
   logic [IDX_W-1:0]    rd_addr_a;
   logic [IDX_W-1:0]    rd_addr_b;
   krt_pkg::record_type rd_data_a;
   krt_pkg::record_type rd_data_b;

   logic [krt_pkg::KEY_W-1:0] cmp_b;
   krt_pkg::cmp_type          cmp_res;

   logic                found;
   logic                srch_end;
   logic                full;
   logic                bad_new_key;
   logic                del_end;
   logic                pass_end;
   logic                sort_end;
   logic                list_end;
   krt_pkg::record_type merged;

   krt_store #(.CAPACITY(CAPACITY)) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   assign cmp_b = (state_ff == krt_pkg::ST_SORT_CMP) ? rd_data_b.key
                                                     : req_ff.key[krt_pkg::KEY_W-1:0];

   krt_keycmp u_keycmp (
      .key_a  (rd_data_a.key),
      .key_b  (cmp_b),
      .result (cmp_res)
   );

   always_comb begin
      full        = (count_ff == CNT_W'(CAPACITY));
      found       = cmp_res.eq && (count_ff != '0);
      srch_end    = found || (count_ff == '0) || (CNT_W'(idx_ff) + CNT_W'(1) == count_ff);
      bad_new_key = ((req_ff.which_field == krt_pkg::FLD_KEY) ||
                     (req_ff.which_field == krt_pkg::FLD_ALL)) &&
                    !krt_pkg::key_in_range(req_ff.new_key);
      del_end     = (CNT_W'(idx_ff) + CNT_W'(1) == count_ff);
      pass_end    = (CNT_W'(idx_ff) + CNT_W'(pass_ff) + CNT_W'(2) == count_ff);
      sort_end    = (CNT_W'(pass_ff) + CNT_W'(2) == count_ff);
      list_end    = (CNT_W'(idx_ff) + CNT_W'(1) == count_ff);
      merged      = rec_ff;
      if (req_ff.which_field == krt_pkg::FLD_KEY || req_ff.which_field == krt_pkg::FLD_ALL) begin
         merged.key = req_ff.new_key[krt_pkg::KEY_W-1:0];
      end
      if (req_ff.which_field == krt_pkg::FLD_PRICE || req_ff.which_field == krt_pkg::FLD_ALL) begin
         merged.price = req_ff.price_cents;
      end
      if (req_ff.which_field == krt_pkg::FLD_QTY || req_ff.which_field == krt_pkg::FLD_ALL) begin
         merged.quantity = req_ff.quantity;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         krt_pkg::ST_IDLE: begin
            if (start) begin
               case (req_data.action)
                  krt_pkg::ACT_INSERT: begin
                     if (!full && krt_pkg::key_in_range(req_data.key)) begin
                        state_in = krt_pkg::ST_SRCH_RD;
                     end
                  end
                  krt_pkg::ACT_LOOKUP, krt_pkg::ACT_UPDATE, krt_pkg::ACT_DELETE: begin
                     if (count_ff != '0 && krt_pkg::key_in_range(req_data.key)) begin
                        state_in = krt_pkg::ST_SRCH_RD;
                     end
                  end
                  krt_pkg::ACT_LIST: begin
                     if (count_ff == CNT_W'(1)) begin
                        state_in = krt_pkg::ST_LIST_RD;
                     end else if (count_ff != '0) begin
                        state_in = krt_pkg::ST_SORT_RD;
                     end
                  end
                  default: state_in = krt_pkg::ST_IDLE;
               endcase
            end
         end
         krt_pkg::ST_SRCH_RD: state_in = krt_pkg::ST_SRCH_CMP;
         krt_pkg::ST_SRCH_CMP: begin
            if (!srch_end) begin
               state_in = krt_pkg::ST_SRCH_RD;
            end else begin
               state_in = krt_pkg::ST_IDLE;
               case (req_ff.action)
                  krt_pkg::ACT_INSERT: begin
                     if (!found && !req_ff.price_cents[31] && !req_ff.quantity[31]) begin
                        state_in = krt_pkg::ST_INS_WR;
                     end
                  end
                  krt_pkg::ACT_UPDATE: begin
                     if (found && !bad_new_key) begin
                        state_in = krt_pkg::ST_UPD_WR;
                     end
                  end
                  krt_pkg::ACT_DELETE: begin
                     if (found) begin
                        state_in = krt_pkg::ST_DEL_RD;
                     end
                  end
                  default: state_in = krt_pkg::ST_IDLE;
               endcase
            end
         end
         krt_pkg::ST_INS_WR: state_in = krt_pkg::ST_IDLE;
         krt_pkg::ST_UPD_WR: state_in = krt_pkg::ST_IDLE;
         krt_pkg::ST_DEL_RD: state_in = del_end ? krt_pkg::ST_IDLE : krt_pkg::ST_DEL_WR;
         krt_pkg::ST_DEL_WR: state_in = krt_pkg::ST_DEL_RD;
         krt_pkg::ST_SORT_RD: state_in = krt_pkg::ST_SORT_CMP;
         krt_pkg::ST_SORT_CMP: begin
            if (cmp_res.gt) begin
               state_in = krt_pkg::ST_SORT_WR;
            end else if (pass_end && sort_end) begin
               state_in = krt_pkg::ST_LIST_RD;
            end else begin
               state_in = krt_pkg::ST_SORT_RD;
            end
         end
         krt_pkg::ST_SORT_WR: begin
            state_in = (pass_end && sort_end) ? krt_pkg::ST_LIST_RD : krt_pkg::ST_SORT_RD;
         end
         krt_pkg::ST_LIST_RD: state_in = krt_pkg::ST_LIST_EMIT;
         krt_pkg::ST_LIST_EMIT: state_in = list_end ? krt_pkg::ST_IDLE : krt_pkg::ST_LIST_RD;
         default: state_in = krt_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      req_in       = req_ff;
      idx_in       = idx_ff;
      pass_in      = pass_ff;
      count_in     = count_ff;
      rec_in       = rec_ff;
      rsp_in       = '0;
      rsp_in.last  = 1'b1;
      rsp_valid_in = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = rd_data_a;
      rd_addr_a    = idx_ff;
      rd_addr_b    = idx_ff + IDX_W'(1);
      case (state_ff)
         krt_pkg::ST_IDLE: begin
            if (start) begin
               req_in  = req_data;
               idx_in  = '0;
               pass_in = '0;
               case (req_data.action)
                  krt_pkg::ACT_INSERT: begin
                     if (full) begin
                        rsp_in.status = krt_pkg::STS_FULL;
                        rsp_valid_in  = 1'b1;
                     end else if (!krt_pkg::key_in_range(req_data.key)) begin
                        rsp_in.status = krt_pkg::STS_BAD_KEY;
                        rsp_valid_in  = 1'b1;
                     end
                  end
                  krt_pkg::ACT_LOOKUP, krt_pkg::ACT_UPDATE: begin
                     if (count_ff == '0 || !krt_pkg::key_in_range(req_data.key)) begin
                        rsp_in.status = krt_pkg::STS_NOT_FOUND;
                        rsp_valid_in  = 1'b1;
                     end
                  end
                  krt_pkg::ACT_DELETE: begin
                     if (count_ff == '0) begin
                        rsp_in.status = krt_pkg::STS_EMPTY;
                        rsp_valid_in  = 1'b1;
                     end else if (!krt_pkg::key_in_range(req_data.key)) begin
                        rsp_in.status = krt_pkg::STS_NOT_FOUND;
                        rsp_valid_in  = 1'b1;
                     end
                  end
                  krt_pkg::ACT_LIST: begin
                     if (count_ff == '0) begin
                        rsp_in.status = krt_pkg::STS_EMPTY;
                        rsp_valid_in  = 1'b1;
                     end
                  end
                  default: rsp_valid_in = 1'b0;
               endcase
            end
         end
         krt_pkg::ST_SRCH_CMP: begin
            if (!srch_end) begin
               idx_in = idx_ff + IDX_W'(1);
            end else begin
               rec_in = rd_data_a;
               case (req_ff.action)
                  krt_pkg::ACT_INSERT: begin
                     if (found) begin
                        rsp_in.status = krt_pkg::STS_DUPLICATE;
                        rsp_valid_in  = 1'b1;
                     end else if (req_ff.price_cents[31]) begin
                        rsp_in.status = krt_pkg::STS_NEG_PRICE;
                        rsp_valid_in  = 1'b1;
                     end else if (req_ff.quantity[31]) begin
                        rsp_in.status = krt_pkg::STS_NEG_QTY;
                        rsp_valid_in  = 1'b1;
                     end
                  end
                  krt_pkg::ACT_LOOKUP: begin
                     rsp_valid_in = 1'b1;
                     if (found) begin
                        rsp_in.status         = krt_pkg::STS_OK;
                        rsp_in.found_key      = rd_data_a.key;
                        rsp_in.found_price    = rd_data_a.price;
                        rsp_in.found_quantity = rd_data_a.quantity;
                     end else begin
                        rsp_in.status = krt_pkg::STS_NOT_FOUND;
                     end
                  end
                  krt_pkg::ACT_UPDATE: begin
                     if (!found) begin
                        rsp_in.status = krt_pkg::STS_NOT_FOUND;
                        rsp_valid_in  = 1'b1;
                     end else if (bad_new_key) begin
                        rsp_in.status         = krt_pkg::STS_BAD_NEW_KEY;
                        rsp_in.found_key      = rd_data_a.key;
                        rsp_in.found_price    = rd_data_a.price;
                        rsp_in.found_quantity = rd_data_a.quantity;
                        rsp_valid_in          = 1'b1;
                     end
                  end
                  krt_pkg::ACT_DELETE: begin
                     if (!found) begin
                        rsp_in.status = krt_pkg::STS_NOT_FOUND;
                        rsp_valid_in  = 1'b1;
                     end
                  end
                  default: rsp_valid_in = 1'b0;
               endcase
            end
         end
         krt_pkg::ST_INS_WR: begin
            wr_en                 = 1'b1;
            wr_addr               = count_ff[IDX_W-1:0];
            wr_data.key           = req_ff.key[krt_pkg::KEY_W-1:0];
            wr_data.price         = req_ff.price_cents;
            wr_data.quantity      = req_ff.quantity;
            count_in              = count_ff + CNT_W'(1);
            rsp_in.status         = krt_pkg::STS_OK;
            rsp_in.found_key      = req_ff.key[krt_pkg::KEY_W-1:0];
            rsp_in.found_price    = req_ff.price_cents;
            rsp_in.found_quantity = req_ff.quantity;
            rsp_valid_in          = 1'b1;
         end
         krt_pkg::ST_UPD_WR: begin
            wr_en                 = 1'b1;
            wr_data               = merged;
            rsp_in.status         = krt_pkg::STS_OK;
            rsp_in.found_key      = merged.key;
            rsp_in.found_price    = merged.price;
            rsp_in.found_quantity = merged.quantity;
            rsp_valid_in          = 1'b1;
         end
         krt_pkg::ST_DEL_RD: begin
            if (del_end) begin
               count_in              = count_ff - CNT_W'(1);
               rsp_in.status         = krt_pkg::STS_OK;
               rsp_in.found_key      = rec_ff.key;
               rsp_in.found_price    = rec_ff.price;
               rsp_in.found_quantity = rec_ff.quantity;
               rsp_valid_in          = 1'b1;
            end else begin
               rd_addr_a = idx_ff + IDX_W'(1);
            end
         end
         krt_pkg::ST_DEL_WR: begin
            // close the gap: move the next record down one slot
            wr_en  = 1'b1;
            idx_in = idx_ff + IDX_W'(1);
         end
         krt_pkg::ST_SORT_CMP: begin
            if (cmp_res.gt) begin
               wr_en   = 1'b1;
               wr_addr = idx_ff + IDX_W'(1);
               rec_in  = rd_data_b;
            end else if (pass_end) begin
               idx_in  = '0;
               pass_in = pass_ff + IDX_W'(1);
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         krt_pkg::ST_SORT_WR: begin
            wr_en   = 1'b1;
            wr_data = rec_ff;
            if (pass_end) begin
               idx_in  = '0;
               pass_in = pass_ff + IDX_W'(1);
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         krt_pkg::ST_LIST_EMIT: begin
            rsp_in.status         = krt_pkg::STS_OK;
            rsp_in.found_key      = rd_data_a.key;
            rsp_in.found_price    = rd_data_a.price;
            rsp_in.found_quantity = rd_data_a.quantity;
            rsp_in.last           = list_end;
            rsp_valid_in          = 1'b1;
            idx_in                = idx_ff + IDX_W'(1);
         end
         default: rsp_valid_in = 1'b0;
      endcase
      rsp_in.entries_held = krt_pkg::HELD_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= krt_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      idx_ff  <= idx_in;
      pass_ff <= pass_in;
      rec_ff  <= rec_in;
      rsp_ff  <= rsp_in;
   end

   assign busy      = (state_ff != krt_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `KRT_ASSERT_NOW(a_held_bound, clock, reset, rsp_valid, rsp_data.entries_held <= krt_pkg::HELD_W'(CAPACITY), "entry count above capacity")
   `KRT_ASSERT_NOW(a_more_busy, clock, reset, rsp_valid && !rsp_data.last, busy, "idle with list output pending")
   `KRT_ASSERT_NOW(a_last_idle, clock, reset, rsp_valid && rsp_data.last, !busy, "busy after final response")
   `KRT_ASSERT_NEXT(a_cmd_taken, clock, reset, start && !busy && req_data.action == krt_pkg::ACT_LIST && count_ff != '0, busy, "list command dropped")

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the keyed record table against a cycle-free model of the table.
// Directed tests cover every action, the insert checks in order, bad new keys
// and the empty table. Random traffic with random gaps follows, then the
// table is filled to capacity, overflowed, listed and trimmed.
// Each response is compared with the oldest predicted one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

   localparam int CAP       = krt_pkg::DEFAULT_CAPACITY;
   localparam int MAX_CYC   = 3000000;
   localparam int DRAIN_CYC = 200;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   krt_pkg::req_type req_data;
   logic             rsp_valid;
   krt_pkg::rsp_type rsp_data;

   keyed_record_table #(.CAPACITY(CAP)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // shadow copy of the table
   logic [krt_pkg::KEY_W-1:0] tbl_key   [CAP];
   logic [31:0]               tbl_price [CAP];
   logic [31:0]               tbl_qty   [CAP];
   int                        tbl_count;

   krt_pkg::rsp_type pending_rsp[$];
   int               mismatches;
   int               cycles;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // ---------------------------------------------------------------- model
   function automatic int find_key(logic signed [15:0] k);
      if (k < 0 || k > krt_pkg::KEY_MAX) return -1;
      for (int i = 0; i < tbl_count; i++)
         if (tbl_key[i] == k[krt_pkg::KEY_W-1:0]) return i;
      return -1;
   endfunction

   task automatic queue_rsp(krt_pkg::status_type sts, int idx, logic lst);
      krt_pkg::rsp_type r;
      r.status         = sts;
      r.found_key      = (idx >= 0) ? tbl_key[idx] : '0;
      r.found_price    = (idx >= 0) ? tbl_price[idx] : '0;
      r.found_quantity = (idx >= 0) ? tbl_qty[idx] : '0;
      r.entries_held   = tbl_count[krt_pkg::HELD_W-1:0];
      r.last           = lst;
      pending_rsp.push_back(r);
   endtask

   task automatic predict_table(krt_pkg::req_type q);
      int                        idx;
      logic [krt_pkg::KEY_W-1:0] tk;
      logic [31:0]               tp;
      logic [31:0]               tq;
      krt_pkg::rsp_type          r;
      idx = find_key(q.key);
      case (q.action)
         krt_pkg::ACT_INSERT: begin
            if (tbl_count >= CAP) queue_rsp(krt_pkg::STS_FULL, -1, 1'b1);
            else if (q.key < 0 || q.key > krt_pkg::KEY_MAX)
               queue_rsp(krt_pkg::STS_BAD_KEY, -1, 1'b1);
            else if (idx >= 0) queue_rsp(krt_pkg::STS_DUPLICATE, -1, 1'b1);
            else if (q.price_cents < 0) queue_rsp(krt_pkg::STS_NEG_PRICE, -1, 1'b1);
            else if (q.quantity < 0) queue_rsp(krt_pkg::STS_NEG_QTY, -1, 1'b1);
            else begin
               tbl_key[tbl_count]   = q.key[krt_pkg::KEY_W-1:0];
               tbl_price[tbl_count] = q.price_cents;
               tbl_qty[tbl_count]   = q.quantity;
               tbl_count++;
               queue_rsp(krt_pkg::STS_OK, tbl_count - 1, 1'b1);
            end
         end
         krt_pkg::ACT_LOOKUP:
            queue_rsp(idx >= 0 ? krt_pkg::STS_OK : krt_pkg::STS_NOT_FOUND, idx, 1'b1);
         krt_pkg::ACT_UPDATE: begin
            if (idx < 0) queue_rsp(krt_pkg::STS_NOT_FOUND, -1, 1'b1);
            else if ((q.which_field == krt_pkg::FLD_KEY ||
                      q.which_field == krt_pkg::FLD_ALL) &&
                     (q.new_key < 0 || q.new_key > krt_pkg::KEY_MAX))
               queue_rsp(krt_pkg::STS_BAD_NEW_KEY, idx, 1'b1);
            else begin
               if (q.which_field == krt_pkg::FLD_KEY || q.which_field == krt_pkg::FLD_ALL)
                  tbl_key[idx] = q.new_key[krt_pkg::KEY_W-1:0];
               if (q.which_field == krt_pkg::FLD_PRICE || q.which_field == krt_pkg::FLD_ALL)
                  tbl_price[idx] = q.price_cents;
               if (q.which_field == krt_pkg::FLD_QTY || q.which_field == krt_pkg::FLD_ALL)
                  tbl_qty[idx] = q.quantity;
               queue_rsp(krt_pkg::STS_OK, idx, 1'b1);
            end
         end
         krt_pkg::ACT_DELETE: begin
            if (tbl_count == 0) queue_rsp(krt_pkg::STS_EMPTY, -1, 1'b1);
            else if (idx < 0) queue_rsp(krt_pkg::STS_NOT_FOUND, -1, 1'b1);
            else begin
               r.status         = krt_pkg::STS_OK;
               r.found_key      = tbl_key[idx];
               r.found_price    = tbl_price[idx];
               r.found_quantity = tbl_qty[idx];
               r.last           = 1'b1;
               for (int j = idx; j + 1 < tbl_count; j++) begin
                  tbl_key[j]   = tbl_key[j+1];
                  tbl_price[j] = tbl_price[j+1];
                  tbl_qty[j]   = tbl_qty[j+1];
               end
               tbl_count--;
               r.entries_held = tbl_count[krt_pkg::HELD_W-1:0];
               pending_rsp.push_back(r);
            end
         end
         krt_pkg::ACT_LIST: begin
            if (tbl_count == 0) queue_rsp(krt_pkg::STS_EMPTY, -1, 1'b1);
            else begin
               // stable bubble sort: swap only on strictly greater
               for (int i = 0; i + 1 < tbl_count; i++)
                  for (int j = 0; j + 1 < tbl_count - i; j++)
                     if (tbl_key[j] > tbl_key[j+1]) begin
                        tk = tbl_key[j];   tbl_key[j]   = tbl_key[j+1];   tbl_key[j+1]   = tk;
                        tp = tbl_price[j]; tbl_price[j] = tbl_price[j+1]; tbl_price[j+1] = tp;
                        tq = tbl_qty[j];   tbl_qty[j]   = tbl_qty[j+1];   tbl_qty[j+1]   = tq;
                     end
               for (int i = 0; i < tbl_count; i++)
                  queue_rsp(krt_pkg::STS_OK, i, i + 1 == tbl_count);
            end
         end
         default: ;  // unknown action: no response, table unchanged
      endcase
   endtask

   // ---------------------------------------------------------------- checker
   always @(posedge clock) begin
      krt_pkg::rsp_type exp_rsp;
      logic             bad;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response %p", rsp_data);
         end else begin
            exp_rsp = pending_rsp.pop_front();
            bad = (rsp_data.status != exp_rsp.status) ||
                  (rsp_data.found_key != exp_rsp.found_key) ||
                  (rsp_data.found_price != exp_rsp.found_price) ||
                  (rsp_data.found_quantity != exp_rsp.found_quantity) ||
                  (rsp_data.entries_held != exp_rsp.entries_held) ||
                  (rsp_data.last != exp_rsp.last);
            if (bad) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("response mismatch: expected %p, got %p", exp_rsp, rsp_data);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > MAX_CYC) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // ---------------------------------------------------------------- driver
   // Raise start with the transaction and hold it until accepted. Busy is
   // stable at the falling edge, so the next rising edge takes it when low.
   task automatic send_req(krt_pkg::action_type act, logic signed [15:0] k,
                           logic signed [15:0] nk, logic signed [31:0] p,
                           logic signed [31:0] qn, krt_pkg::field_type wf);
      krt_pkg::req_type q;
      q.action = act; q.key = k; q.new_key = nk;
      q.price_cents = p; q.quantity = qn; q.which_field = wf;
      @(negedge clock);
      start    = 1'b1;
      req_data = q;
      while (busy) @(negedge clock);
      @(posedge clock);
      predict_table(q);
   endtask

   task automatic idle_gap();
      int n;
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) n = 0;
      else if (roll < 93) n = $urandom_range(1, 3);
      else n = $urandom_range(10, 40);
      if (n > 0) begin
         @(negedge clock);
         start = 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      start = 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
   endtask

   // ---------------------------------------------------------------- tests
   task automatic test_empty_table();
      send_req(krt_pkg::ACT_LOOKUP, 16'sd5, 16'sd0, 32'sd0, 32'sd0, krt_pkg::FLD_KEY);
      send_req(krt_pkg::ACT_UPDATE, 16'sd5, 16'sd6, 32'sd1, 32'sd1, krt_pkg::FLD_ALL);
      send_req(krt_pkg::ACT_DELETE, 16'sd5, 16'sd0, 32'sd0, 32'sd0, krt_pkg::FLD_KEY);
      send_req(krt_pkg::ACT_LIST, 16'sd0, 16'sd0, 32'sd0, 32'sd0, krt_pkg::FLD_KEY);
   endtask

   task automatic test_insert_checks();
      send_req(krt_pkg::ACT_INSERT, 16'sd9999, 16'sd0, 32'sh7fffffff, 32'sh7fffffff,
               krt_pkg::FLD_KEY);
      send_req(krt_pkg::ACT_INSERT, 16'sd0, 16'sd0, 32'sd0, 32'sd0, krt_pkg::FLD_KEY);
      send_req(krt_pkg::ACT_INSERT, 16'sd10000, 16'sd0, 32'sd1, 32'sd1, krt_pkg::FLD_KEY);
      send_req(krt_pkg::ACT_INSERT, -16'sd1, 16'sd0, 32'sd1, 32'sd1, krt_pkg::FLD_KEY);
      send_req(krt_pkg::ACT_INSERT, 16'sh8000, 16'sh7fff, 32'sh80000000, 32'sh80000000,
               krt_pkg::FLD_ALL);
      send_req(krt_pkg::ACT_INSERT, 16'sh7fff, 16'sh8000, 32'sd1, 32'sd1, krt_pkg::FLD_KEY);
      // duplicate beats negative price
      send_req(krt_pkg::ACT_INSERT, 16'sd0, 16'sd0, -32'sd1, -32'sd1, krt_pkg::FLD_KEY);
      send_req(krt_pkg::ACT_INSERT, 16'sd42, 16'sd0, -32'sd1, -32'sd1, krt_pkg::FLD_KEY);
      send_req(krt_pkg::ACT_INSERT, 16'sd42, 16'sd0, 32'sd7, -32'sd1, krt_pkg::FLD_KEY);
      send_req(krt_pkg::ACT_INSERT, 16'sd42, 16'sd0, 32'sd1250, 32'sd3, krt_pkg::FLD_KEY);
   endtask

   task automatic test_update_paths();
      send_req(krt_pkg::ACT_LOOKUP, 16'sd42, 16'sd0, 32'sd0, 32'sd0, krt_pkg::FLD_KEY);
      send_req(krt_pkg::ACT_UPDATE, 16'sd42, 16'sd0, -32'sd5, 32'sd0, krt_pkg::FLD_PRICE);
      send_req(krt_pkg::ACT_UPDATE, 16'sd42, 16'sd0, 32'sd0, -32'sd9, krt_pkg::FLD_QTY);
      send_req(krt_pkg::ACT_UPDATE, 16'sd42, 16'sd10000, 32'sd1, 32'sd1, krt_pkg::FLD_ALL);
      send_req(krt_pkg::ACT_UPDATE, 16'sd42, -16'sd1, 32'sd1, 32'sd1, krt_pkg::FLD_KEY);
      // new key collides with an existing one; lookup must return the first
      send_req(krt_pkg::ACT_UPDATE, 16'sd42, 16'sd0, 32'sd2, 32'sd2, krt_pkg::FLD_KEY);
      send_req(krt_pkg::ACT_LOOKUP, 16'sd0, 16'sd0, 32'sd0, 32'sd0, krt_pkg::FLD_KEY);
      send_req(krt_pkg::ACT_UPDATE, 16'sd0, 16'sd17, 32'sd55, 32'sd66, krt_pkg::FLD_ALL);
      send_req(krt_pkg::ACT_UPDATE, 16'sd10000, 16'sd1, 32'sd1, 32'sd1, krt_pkg::FLD_PRICE);
      send_req(krt_pkg::ACT_LOOKUP, -16'sd1, 16'sd0, 32'sd0, 32'sd0, krt_pkg::FLD_KEY);
   endtask

   task automatic test_delete_and_list();
      send_req(krt_pkg::ACT_LIST, 16'sd0, 16'sd0, 32'sd0, 32'sd0, krt_pkg::FLD_KEY);
      send_req(krt_pkg::ACT_DELETE, 16'sd10000, 16'sd0, 32'sd0, 32'sd0, krt_pkg::FLD_KEY);
      send_req(krt_pkg::ACT_DELETE, 16'sd123, 16'sd0, 32'sd0, 32'sd0, krt_pkg::FLD_KEY);
      send_req(krt_pkg::ACT_DELETE, 16'sd9999, 16'sd0, 32'sd0, 32'sd0, krt_pkg::FLD_KEY);
      send_req(krt_pkg::action_type'(3'd5), 16'sd0, 16'sd0, 32'sd0, 32'sd0,
               krt_pkg::FLD_KEY);
      send_req(krt_pkg::action_type'(3'd7), 16'sd0, 16'sd0, 32'sd0, 32'sd0,
               krt_pkg::FLD_KEY);
      send_req(krt_pkg::ACT_LIST, 16'sd0, 16'sd0, 32'sd0, 32'sd0, krt_pkg::FLD_KEY);
   endtask

   // Fill to capacity in descending key order, overflow, list, then trim.
   task automatic test_full_table();
      wait_drained();
      while (tbl_count > 0)
         send_req(krt_pkg::ACT_DELETE, 16'(tbl_key[0]), 16'sd0, 32'sd0, 32'sd0,
                  krt_pkg::FLD_KEY);
      for (int i = 0; i < CAP; i++) begin
         send_req(krt_pkg::ACT_INSERT, 16'(9000 - 7 * i), 16'sd0,
                  32'($urandom_range(0, 99999)), 32'(i), krt_pkg::FLD_KEY);
         if (i % 16 == 0) idle_gap();
      end
      send_req(krt_pkg::ACT_INSERT, 16'sd1, 16'sd0, 32'sd1, 32'sd1, krt_pkg::FLD_KEY);
      send_req(krt_pkg::ACT_LIST, 16'sd0, 16'sd0, 32'sd0, 32'sd0, krt_pkg::FLD_KEY);
      repeat (4)
         send_req(krt_pkg::ACT_DELETE, 16'(tbl_key[$urandom_range(0, tbl_count - 1)]),
                  16'sd0, 32'sd0, 32'sd0, krt_pkg::FLD_KEY);
   endtask

   function automatic logic signed [15:0] pick_key();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 80) return 16'($urandom_range(0, 40));
      if (roll < 85) return 16'sd9999;
      if (roll < 90) return 16'sd10000;
      return 16'($urandom);
   endfunction

   function automatic logic signed [31:0] pick_amount();
      if ($urandom_range(0, 9) == 0) return 32'($urandom);
      return 32'($urandom & 32'h7fffffff);
   endfunction

   task automatic test_random_traffic(int n_items);
      int                  roll;
      krt_pkg::action_type act;
      for (int i = 0; i < n_items; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < 35) act = krt_pkg::ACT_INSERT;
         else if (roll < 50) act = krt_pkg::ACT_LOOKUP;
         else if (roll < 70) act = krt_pkg::ACT_UPDATE;
         else if (roll < 88) act = krt_pkg::ACT_DELETE;
         else if (roll < 94) act = krt_pkg::ACT_LIST;
         else act = krt_pkg::action_type'(3'($urandom_range(5, 7)));
         send_req(act, pick_key(), pick_key(), pick_amount(), pick_amount(),
                  krt_pkg::field_type'(2'($urandom_range(0, 3))));
         if (i == n_items / 2) wait_drained();  // let the pipe empty once
         else if (i % 30 < 20) idle_gap();
      end
   endtask

   initial begin
      start       = 1'b0;
      req_data    = '0;
      reset       = 1'b1;
      mismatches  = 0;
      cycles      = 0;
      tbl_count   = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_table();
      test_insert_checks();
      test_update_paths();
      test_delete_and_list();
      test_random_traffic(20);
      test_full_table();

      wait_drained();
      repeat (DRAIN_CYC) @(posedge clock);
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
